[src/sidad_pkg.sv]
package sidad_pkg;

  localparam int MAG_W        = 32;
  localparam int DIGIT_W      = 4;
  localparam int BCD_DIGITS   = 10;
  localparam int BCD_W        = BCD_DIGITS * DIGIT_W;
  localparam int DABBLE_STEPS = 8;
  localparam int DABBLE_STGS  = MAG_W / DABBLE_STEPS;
  localparam int IDX_W        = 4;
  localparam int CHAR_W       = 6;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 6'd45;
  localparam logic [DIGIT_W-1:0] DABBLE_LIM  = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJ  = 4'd3;

  // One number in flight: sign, binary bits not yet shifted in, BCD so far.
  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  bin;
    logic [BCD_W-1:0]  bcd;
  } conv_t;

endpackage

[src/sidad_abs.sv]
module sidad_abs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sidad_pkg::MAG_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sidad_pkg::conv_t            out_item
);

  logic             vld_r;
  sidad_pkg::conv_t item_r;
  sidad_pkg::conv_t item_nxt;

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    item_nxt.neg = in_value[sidad_pkg::MAG_W-1];
    item_nxt.bin = item_nxt.neg ? (~in_value + 1'b1) : in_value;
    item_nxt.bcd = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule

[src/sidad_dabble.sv]
module sidad_dabble (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sidad_pkg::conv_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output sidad_pkg::conv_t out_item
);

  logic             vld_r;
  sidad_pkg::conv_t item_r;
  sidad_pkg::conv_t item_nxt;

  assign in_ready = !vld_r || out_ready;

  // Shift-and-add-3: several binary bits move into the BCD field per stage.
  always_comb begin
    item_nxt = in_item;
    for (int s = 0; s < sidad_pkg::DABBLE_STEPS; s++) begin
      for (int d = 0; d < sidad_pkg::BCD_DIGITS; d++) begin
        if (item_nxt.bcd[d*sidad_pkg::DIGIT_W +: sidad_pkg::DIGIT_W] >= sidad_pkg::DABBLE_LIM)
        begin
          item_nxt.bcd[d*sidad_pkg::DIGIT_W +: sidad_pkg::DIGIT_W] =
            item_nxt.bcd[d*sidad_pkg::DIGIT_W +: sidad_pkg::DIGIT_W] + sidad_pkg::DABBLE_ADJ;
        end
      end
      {item_nxt.bcd, item_nxt.bin} = {item_nxt.bcd[sidad_pkg::BCD_W-2:0], item_nxt.bin, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule

[src/sidad_emit.sv]
module sidad_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sidad_pkg::conv_t             in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sidad_pkg::CHAR_W-1:0] out_char,
  output logic                         out_last
);

  logic                          busy_r;
  logic                          neg_r;
  logic [sidad_pkg::IDX_W-1:0]   idx_r;
  logic [sidad_pkg::BCD_W-1:0]   bcd_r;
  logic                          ovld_r;
  logic [sidad_pkg::CHAR_W-1:0]  char_r;
  logic                          last_r;

  logic                          out_ok;
  logic                          emit;
  logic                          fin;
  logic                          load;
  logic [sidad_pkg::IDX_W-1:0]   top;
  logic [sidad_pkg::DIGIT_W-1:0] digit;
  logic [sidad_pkg::CHAR_W-1:0]  char_nxt;

  assign out_ok   = !ovld_r || out_ready;
  assign emit     = busy_r && out_ok;
  assign fin      = !neg_r && (idx_r == '0);
  assign in_ready = !busy_r || (emit && fin);
  assign load     = in_valid && in_ready;

  // Most significant nonzero digit; zero keeps digit 0.
  always_comb begin
    top = '0;
    for (int d = 1; d < sidad_pkg::BCD_DIGITS; d++) begin
      if (in_item.bcd[d*sidad_pkg::DIGIT_W +: sidad_pkg::DIGIT_W] != '0) begin
        top = sidad_pkg::IDX_W'(d);
      end
    end
  end

  assign digit    = bcd_r[idx_r*sidad_pkg::DIGIT_W +: sidad_pkg::DIGIT_W];
  assign char_nxt = neg_r ? sidad_pkg::ASCII_MINUS
                          : sidad_pkg::ASCII_ZERO + {2'b00, digit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
      neg_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        neg_r  <= in_item.neg;
        idx_r  <= top;
      end else if (emit && fin) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        if (neg_r) begin
          neg_r <= 1'b0;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
      if (emit) begin
        ovld_r <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r <= in_item.bcd;
    end
    if (emit) begin
      char_r <= char_nxt;
      last_r <= fin;
    end
  end

  assign out_valid = ovld_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r < sidad_pkg::IDX_W'(sidad_pkg::BCD_DIGITS))
    else $error("digit index out of range");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> (char_r == sidad_pkg::ASCII_MINUS ||
                (char_r >= sidad_pkg::ASCII_ZERO && char_r <= sidad_pkg::ASCII_ZERO + 6'd9)))
    else $error("illegal character code");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && char_r == sidad_pkg::ASCII_MINUS) |-> !last_r)
    else $error("minus sign flagged as last");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && neg_r) |=> (busy_r && !neg_r))
    else $error("minus sign not followed by a digit");

endmodule

[src/signed_int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text.
// Input channel: one transfer per number, in_tdata holds the two's
// complement value. Output channel: one transfer per character, a '-'
// for negative values and then the digits, most significant first, with
// no leading zeros (zero gives "0"). out_tlast marks the final character,
// so a number yields 1 to 11 transfers.
// Datapath: a sign/magnitude register, four double-dabble stages of eight
// shift-and-add-3 steps each, then a serializer feeding an output register.
// An input number passes the sign/magnitude register, four dabble stages
// and the serializer's load into the output register. Throughput: one
// character per cycle while the receiver is ready; the serializer sends a
// number's characters back to back, and the stages ahead keep accepting
// numbers while it works, so in_tready stays high as long as a stage is free.
// Reset clears all valid bits; nothing is in flight afterward.
// When the receiver stalls, the output register holds its character and
// the stall backs up through the stages; nothing is dropped or repeated.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] char_code, [7:6] zero
  output logic        out_tlast   // last character of the number
);

  logic             vld   [sidad_pkg::DABBLE_STGS+1];
  logic             rdy   [sidad_pkg::DABBLE_STGS+1];
  sidad_pkg::conv_t item  [sidad_pkg::DABBLE_STGS+1];
  logic [sidad_pkg::CHAR_W-1:0] char_code;

  // Sign and magnitude.
  sidad_abs u_abs (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_item  (item[0])
  );

  // Binary to BCD, a slice of the bits per stage.
  for (genvar g = 0; g < sidad_pkg::DABBLE_STGS; g++) begin : g_dabble
    sidad_dabble u_dabble (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_item   (item[g]),
      .out_valid (vld[g+1]),
      .out_ready (rdy[g+1]),
      .out_item  (item[g+1])
    );
  end

  // One character per transfer.
  sidad_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld[sidad_pkg::DABBLE_STGS]),
    .in_ready  (rdy[sidad_pkg::DABBLE_STGS]),
    .in_item   (item[sidad_pkg::DABBLE_STGS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (char_code),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, char_code};

endmodule

[sim/decimal_text_checker.sv]
module decimal_text_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          chars_owed
);

  localparam logic [31:0] DEC_BASE = 32'd10;

  typedef struct packed {
    logic [sidad_pkg::CHAR_W-1:0] code;
    logic                         fin;
  } text_char_t;

  text_char_t pending_chars[$];

  initial mismatch_count = 0;

  // Expected text of one number, queued one character per entry.
  function automatic void queue_decimal_text(input logic [31:0] value);
    logic [31:0]                   mag;
    logic [sidad_pkg::DIGIT_W-1:0] digits[$];
    logic [sidad_pkg::DIGIT_W-1:0] d;
    text_char_t                    c;
    // magnitude as unsigned, so the most negative value needs no special path
    mag = value[31] ? (~value + 32'd1) : value;
    do begin
      digits.push_front(sidad_pkg::DIGIT_W'(mag % DEC_BASE));
      mag = mag / DEC_BASE;
    end while (mag != 32'd0);
    if (value[31]) begin
      c.code = sidad_pkg::ASCII_MINUS;
      c.fin  = 1'b0;
      pending_chars.push_back(c);
    end
    while (digits.size() > 0) begin
      d      = digits.pop_front();
      c.code = sidad_pkg::ASCII_ZERO + sidad_pkg::CHAR_W'(d);
      c.fin  = (digits.size() == 0);
      pending_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      pending_chars.delete();
    end else begin
      if (in_tvalid === 1'b1 && in_tready === 1'b1)
        queue_decimal_text(in_tdata);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected character transfer: char_code %0d, last %0b",
                 out_tdata[sidad_pkg::CHAR_W-1:0], out_tlast);
          mismatch_count++;
        end else begin
          want = pending_chars.pop_front();
          if (out_tdata[sidad_pkg::CHAR_W-1:0] !== want.code) begin
            $error("char_code: expected %0d, got %0d", want.code,
                   out_tdata[sidad_pkg::CHAR_W-1:0]);
            mismatch_count++;
          end
          if (out_tlast !== want.fin) begin
            $error("last: expected %0b, got %0b", want.fin, out_tlast);
            mismatch_count++;
          end
          if (out_tdata[7:sidad_pkg::CHAR_W] !== '0) begin
            $error("tdata pad: expected 0, got %0d", out_tdata[7:sidad_pkg::CHAR_W]);
            mismatch_count++;
          end
        end
      end
    end
    chars_owed <= pending_chars.size();
  end

endmodule

[sim/tb_signed_int_to_decimal_ascii.sv]
module tb_signed_int_to_decimal_ascii;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  int mismatch_count;
  int chars_owed;

  // Sender bookkeeping; the receiver reads numbers_sent to time its long hold.
  int numbers_sent = 0;
  int burst_left   = 0;
  bit stim_done    = 1'b0;

  always #5 clk = ~clk;

  signed_int_to_decimal_ascii dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Watches both channels, predicts the text of every accepted number and
  // compares it character by character.
  decimal_text_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .chars_owed     (chars_owed)
  );

  // Offer one number and hold it until the transfer. Inputs change only
  // through NBAs at the rising edge; in_tready read right after the edge is
  // the value that decided the transfer. Between bursts in_tvalid drops for
  // a random gap; within a burst it stays high, so back-to-back numbers are
  // offered without a bubble.
  task automatic offer_number(input logic [31:0] value);
    int gap;
    in_tdata  <= value;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    numbers_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      // mostly short bursts, now and then a long run without gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  // Stimulus: reset, directed corner values, then random numbers.
  initial begin : stim
    logic [31:0] value;
    logic [31:0] corner_vals[$];
    int          shift;
    corner_vals = '{
      32'd0,          32'd1,          32'hFFFF_FFFF,  32'd9,
      32'd10,         -32'sd10,       32'd99,         32'd100,
      -32'sd9,        32'h7FFF_FFFF,  32'h8000_0000,  32'h8000_0001,
      32'h7FFF_FFFE,  32'd999999999,  32'd1000000000, -32'sd999999999,
      -32'sd1000000000, 32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
      32'd12345,      -32'sd100
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners: zero, one digit, digit-count boundaries, both ends of the range
    // (the most negative value included), alternating bit patterns
    foreach (corner_vals[i]) offer_number(corner_vals[i]);

    // random numbers: a right shift spreads the digit count over 1..10,
    // and half of them are negated; a quarter use all 32 random bits
    repeat (338) begin
      if ($urandom_range(0, 3) == 0) begin
        value = $urandom;
      end else begin
        shift = $urandom_range(0, 31);
        value = $urandom >> shift;
        if ($urandom_range(0, 1) == 1) value = -value;
      end
      offer_number(value);
    end

    in_tvalid <= 1'b0;
    stim_done = 1'b1;

    // chars_owed is updated by NBA, so it lags the transfer that it counts
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
    // allow stray output to show up after the queue is empty
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("signed_int_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii regression: fail");
    end
    $finish;
  end

  // Receiver: out_tready gets at most one NBA per edge. Modes switch at
  // random between always ready, half ready and mostly stalled.
  // Once, after the first numbers are accepted, it holds off for a long
  // stretch so the stages fill and in_tready drops while the sender keeps
  // offering.
  initial begin : sink
    int  mode;
    int  mode_left;
    bit  held;
    mode      = 0;
    mode_left = 0;
    held      = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (stim_done) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (!held && numbers_sent >= 60) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            out_tready <= ($urandom_range(0, 3) == 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin : watchdog
    #3000000;
    $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

endmodule
